// ===== rtl/djent_pkg.sv =====
// Shared types and constants for the discrete joint entropy block.
package djent_pkg;

    // Fraction bits of the log result and ln(2) in Q0.32
    localparam int unsigned LN_FRAC_BITS = 28;
    localparam logic [31:0] LN2_Q32      = 32'hB172_17F8;

    // Lane width of the input fields
    localparam int unsigned FIELD_BITS   = 16;
    localparam int unsigned LANES        = 4;

    // Control bits that travel with a sample from cell to cell
    typedef struct packed {
        logic valid;
        logic found;
    } link_t;

    // Top-level sequencer
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_DRAIN,
        ST_LN_TOT,
        ST_TOT_ACC,
        ST_SCAN,
        ST_LN_CNT,
        ST_ACC,
        ST_DIV,
        ST_DONE
    } djent_state_t;

    // Log unit sequencer
    typedef enum logic [1:0] {
        LN_IDLE,
        LN_SQ,
        LN_K,
        LN_FIN
    } lnq_state_t;

endpackage

// ===== rtl/djent_if.sv =====
// Channel interfaces: sample input, result output and configuration write.
interface djent_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] value_0;
    logic [15:0] value_1;
    logic [15:0] value_2;
    logic [15:0] value_3;
    logic        last_sample;

    modport source (output valid, value_0, value_1, value_2, value_3, last_sample,
                    input ready);
    modport sink   (input valid, value_0, value_1, value_2, value_3, last_sample,
                    output ready);
endinterface

interface djent_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] entropy_nats;
    logic [10:0] distinct_patterns;
    logic [10:0] sample_total;
    logic        overflow;

    modport source (output valid, entropy_nats, distinct_patterns, sample_total, overflow,
                    input ready);
    modport sink   (input valid, entropy_nats, distinct_patterns, sample_total, overflow,
                    output ready);
endinterface

interface djent_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/djent_cell.sv =====
// One pattern cell: holds a key and its count, matches passing samples.
module djent_cell #(
    parameter int unsigned KW = 64,
    parameter int unsigned CW = 11
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   shift,
    input  djent_pkg::link_t       link_in,
    input  logic [KW-1:0]          key_in,
    output djent_pkg::link_t       link_out,
    output logic [KW-1:0]          key_out,
    input  logic                   prev_valid,
    input  logic [CW-1:0]          prev_count,
    output logic                   valid,
    output logic [CW-1:0]          count
);

    logic             valid_reg;
    logic [KW-1:0]    key_reg;
    logic [CW-1:0]    count_reg;
    djent_pkg::link_t link_reg;
    logic [KW-1:0]    pass_key_reg;
    logic             take;
    logic             hit;

    assign take = link_in.valid && !link_in.found;
    assign hit  = valid_reg && (key_reg == key_in);

    // Hold the pattern: claim when empty, count on match, shift out on unload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= prev_valid;
        end
        else if (take && !valid_reg)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            count_reg <= prev_count;
        end
        else if (take && hit)
        begin
            count_reg <= count_reg + CW'(1);
        end
        else if (take && !valid_reg)
        begin
            count_reg <= CW'(1);
            key_reg   <= key_in;
        end
    end

    // Pass the sample on to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg.valid <= link_in.valid && !shift;
            link_reg.found <= link_in.found || (take && (hit || !valid_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        pass_key_reg <= key_in;
    end

    assign link_out = link_reg;
    assign key_out  = pass_key_reg;
    assign valid    = valid_reg;
    assign count    = count_reg;

endmodule

// ===== rtl/djent_lnq.sv =====
// Natural log in Q.28 by repeated squaring, one fraction bit per cycle.
module djent_lnq #(
    parameter int unsigned CW = 11
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [CW-1:0] x,
    output logic        done,
    output logic [31:0] result
);

    localparam int unsigned EW = (CW > 1) ? $clog2(CW) : 1;

    djent_pkg::lnq_state_t state_reg, state_next;
    logic [63:0]   prod_reg;
    logic [27:0]   frac_reg;
    logic [EW-1:0] e_reg;
    logic [4:0]    iter_reg;
    logic          hi_reg;
    logic [31:0]   result_reg;
    logic          done_reg;

    logic [EW-1:0] e_top;
    logic [31:0]   m0;
    logic [32:0]   sq_t;
    logic [31:0]   m_norm;
    logic [32:0]   l2;
    logic [64:0]   full;
    logic          iter_last;
    logic          load_start;

    // Find the top set bit
    always_comb
    begin
        e_top = '0;
        for (int i = 0; i < CW; i++)
        begin
            if (x[i])
            begin
                e_top = EW'(i);
            end
        end
    end

    assign m0     = 32'(x) << (5'd31 - 5'(e_top));
    assign sq_t   = prod_reg[63:31];
    assign m_norm = sq_t[32] ? sq_t[32:1] : sq_t[31:0];
    assign l2     = (33'(e_reg) << djent_pkg::LN_FRAC_BITS) | 33'(frac_reg);
    assign full   = 65'(prod_reg) + (hi_reg ? {1'b0, djent_pkg::LN2_Q32, 32'd0} : 65'd0);
    assign iter_last = (iter_reg == 5'(djent_pkg::LN_FRAC_BITS - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            djent_pkg::LN_IDLE: if (start) state_next = djent_pkg::LN_SQ;
            djent_pkg::LN_SQ:   if (iter_last) state_next = djent_pkg::LN_K;
            djent_pkg::LN_K:    state_next = djent_pkg::LN_FIN;
            djent_pkg::LN_FIN:  state_next = djent_pkg::LN_IDLE;
            default:            state_next = djent_pkg::LN_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        load_start = 1'b0;
        unique case (state_reg)
            djent_pkg::LN_IDLE: load_start = start;
            default:            load_start = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= djent_pkg::LN_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == djent_pkg::LN_FIN);
        end
    end

    // Square, renormalize and collect one fraction bit per cycle
    always_ff @(posedge clk)
    begin
        if (load_start)
        begin
            prod_reg <= m0 * m0;
            e_reg    <= e_top;
            iter_reg <= '0;
            frac_reg <= '0;
        end
        else if (state_reg == djent_pkg::LN_SQ)
        begin
            prod_reg <= m_norm * m_norm;
            frac_reg <= {frac_reg[26:0], sq_t[32]};
            iter_reg <= iter_reg + 5'd1;
        end
        else if (state_reg == djent_pkg::LN_K)
        begin
            prod_reg <= l2[31:0] * djent_pkg::LN2_Q32;
            hi_reg   <= l2[32];
        end
        else if (state_reg == djent_pkg::LN_FIN)
        begin
            result_reg <= full[63:32];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/djent_div.sv =====
// Restoring divider, one quotient bit per cycle.
module djent_div #(
    parameter int unsigned NW = 43,
    parameter int unsigned CW = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [CW-1:0] divisor,
    output logic          done,
    output logic [31:0]   quotient
);

    localparam int unsigned IW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [CW-1:0] rem_reg;
    logic [CW-1:0] dvs_reg;
    logic [IW-1:0] left_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [CW:0]   trial;
    logic          fits;

    assign trial = {rem_reg, q_reg[NW-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    // Busy flag and bit counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            left_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                left_reg <= IW'(NW);
            end
            else if (busy_reg)
            begin
                left_reg <= left_reg - IW'(1);
                if (left_reg == IW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift in one dividend bit and subtract when it fits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[NW-2:0], fits};
            rem_reg <= fits ? CW'(trial - {1'b0, dvs_reg}) : trial[CW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg[31:0];

endmodule

// ===== rtl/discrete_joint_entropy.sv =====
// Top level: pattern cell chain, log unit, divider and result register.
// Loading: one sample per cycle while in the load state; a sample walks the chain
// one cell per cycle. After the last sample the chain is flushed, ln(n) is taken,
// the cells are unloaded with a log for each distinct pattern, and a divider with
// a CW+32-bit dividend forms the result (CW = bits of MAX_SAMPLES).
// Reset empties the cells, clears the counters and the result valid; num_vars resets to 1.
module discrete_joint_entropy #(
    parameter int unsigned MAX_SAMPLES = 1024,
    parameter int unsigned MAX_VARS    = 4,
    parameter int unsigned VALUE_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    djent_sample_if.sink       sample_in,
    djent_result_if.source     result_out,
    djent_cfg_if.sink          cfg
);

    localparam int unsigned N  = MAX_SAMPLES;
    localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned KW = MAX_VARS * VALUE_BITS;
    localparam int unsigned PW = CW + 32;

    djent_pkg::djent_state_t state_reg, state_next;

    logic [2:0]    num_vars_reg;
    logic [CW-1:0] seen_reg;
    logic          drop_reg;
    logic [CW-1:0] tot_reg;
    logic          ovf_reg;
    logic [CW-1:0] drain_reg;
    logic [CW-1:0] scan_reg;
    logic [CW-1:0] distinct_reg;
    logic [CW-1:0] cnt_reg;
    logic [PW-1:0] mul_reg;
    logic [PW-1:0] t_reg;
    logic [PW-1:0] s_reg;

    logic          out_valid_reg;
    logic [31:0]   out_ent_reg;
    logic [10:0]   out_dist_reg;
    logic [10:0]   out_tot_reg;
    logic          out_ovf_reg;

    logic          accept;
    logic          at_cap;
    logic          in_ready;
    logic          inject;
    logic          shift;
    logic          lnq_start;
    logic [CW-1:0] lnq_x;
    logic          lnq_done;
    logic [31:0]   lnq_q;
    logic          div_start;
    logic          div_done;
    logic [31:0]   div_q;
    logic [PW-1:0] dividend;
    logic          scan_done;
    logic          drain_done;
    logic          out_free;
    logic [2:0]    k_eff;
    logic [KW-1:0] key;
    logic [15:0]   lane_val [djent_pkg::LANES];

    djent_pkg::link_t link   [N];
    logic [KW-1:0]    key_ln [N];
    logic             cvalid [N];
    logic [CW-1:0]    ccount [N];

    // Configuration register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_vars_reg <= 3'd1;
        end
        else if (cfg.valid)
        begin
            num_vars_reg <= cfg.data;
        end
    end

    // Build the masked key
    assign lane_val[0] = sample_in.value_0;
    assign lane_val[1] = sample_in.value_1;
    assign lane_val[2] = sample_in.value_2;
    assign lane_val[3] = sample_in.value_3;

    always_comb
    begin
        if (num_vars_reg == 3'd0)
        begin
            k_eff = 3'd1;
        end
        else if (num_vars_reg > 3'(MAX_VARS))
        begin
            k_eff = 3'(MAX_VARS);
        end
        else
        begin
            k_eff = num_vars_reg;
        end
    end

    always_comb
    begin
        for (int l = 0; l < MAX_VARS; l++)
        begin
            key[l*VALUE_BITS +: VALUE_BITS] =
                (3'(l) < k_eff) ? lane_val[l][VALUE_BITS-1:0] : '0;
        end
    end

    assign accept     = sample_in.valid && in_ready;
    assign at_cap     = (seen_reg == CW'(N));
    assign drain_done = (drain_reg == CW'(N - 1));
    assign scan_done  = (scan_reg == CW'(N));
    assign out_free   = !out_valid_reg || result_out.ready;
    assign dividend   = (s_reg >= t_reg) ? '0 : (t_reg - s_reg);

    // Cell chain
    assign link[0] = '{valid: inject, found: 1'b0};
    assign key_ln[0] = key;

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        logic          pv;
        logic [CW-1:0] pc;
        if (g == 0)
        begin : g_head
            assign pv = 1'b0;
            assign pc = '0;
        end
        else
        begin : g_body
            assign pv = cvalid[g-1];
            assign pc = ccount[g-1];
        end

        if (g < N - 1)
        begin : g_mid
            djent_cell #(.KW(KW), .CW(CW)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift      (shift),
                .link_in    (link[g]),
                .key_in     (key_ln[g]),
                .link_out   (link[g+1]),
                .key_out    (key_ln[g+1]),
                .prev_valid (pv),
                .prev_count (pc),
                .valid      (cvalid[g]),
                .count      (ccount[g])
            );
        end
        else
        begin : g_tail
            djent_cell #(.KW(KW), .CW(CW)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift      (shift),
                .link_in    (link[g]),
                .key_in     (key_ln[g]),
                .link_out   (),
                .key_out    (),
                .prev_valid (pv),
                .prev_count (pc),
                .valid      (cvalid[g]),
                .count      (ccount[g])
            );
        end
    end

    // Log and divide units
    djent_lnq #(.CW(CW)) u_lnq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lnq_start),
        .x      (lnq_x),
        .done   (lnq_done),
        .result (lnq_q)
    );

    djent_div #(.NW(PW), .CW(CW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (tot_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            djent_pkg::ST_LOAD:    if (accept && sample_in.last_sample)
                                       state_next = djent_pkg::ST_DRAIN;
            djent_pkg::ST_DRAIN:   if (drain_done) state_next = djent_pkg::ST_LN_TOT;
            djent_pkg::ST_LN_TOT:  if (lnq_done) state_next = djent_pkg::ST_TOT_ACC;
            djent_pkg::ST_TOT_ACC: state_next = djent_pkg::ST_SCAN;
            djent_pkg::ST_SCAN:
            begin
                if (scan_done)
                    state_next = djent_pkg::ST_DIV;
                else if (cvalid[N-1])
                    state_next = djent_pkg::ST_LN_CNT;
            end
            djent_pkg::ST_LN_CNT:  if (lnq_done) state_next = djent_pkg::ST_ACC;
            djent_pkg::ST_ACC:     state_next = djent_pkg::ST_SCAN;
            djent_pkg::ST_DIV:     if (div_done) state_next = djent_pkg::ST_DONE;
            djent_pkg::ST_DONE:    if (out_free) state_next = djent_pkg::ST_LOAD;
            default:               state_next = djent_pkg::ST_LOAD;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready  = 1'b0;
        shift     = 1'b0;
        lnq_start = 1'b0;
        lnq_x     = cnt_reg;
        div_start = 1'b0;
        unique case (state_reg)
            djent_pkg::ST_LOAD:
            begin
                in_ready = 1'b1;
            end
            djent_pkg::ST_DRAIN:
            begin
                lnq_x     = tot_reg;
                lnq_start = drain_done;
            end
            djent_pkg::ST_SCAN:
            begin
                lnq_x     = ccount[N-1];
                shift     = !scan_done;
                lnq_start = !scan_done && cvalid[N-1];
                div_start = scan_done;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign inject          = accept && !at_cap;
    assign sample_in.ready = in_ready;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= djent_pkg::ST_LOAD;
            seen_reg      <= '0;
            drop_reg      <= 1'b0;
            drain_reg     <= '0;
            scan_reg      <= '0;
            distinct_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Count samples and flag drops
            if (accept)
            begin
                if (sample_in.last_sample)
                begin
                    seen_reg  <= '0;
                    drop_reg  <= 1'b0;
                    drain_reg <= '0;
                end
                else if (at_cap)
                begin
                    drop_reg <= 1'b1;
                end
                else
                begin
                    seen_reg <= seen_reg + CW'(1);
                end
            end

            if (state_reg == djent_pkg::ST_DRAIN)
            begin
                drain_reg <= drain_reg + CW'(1);
            end

            if (state_reg == djent_pkg::ST_TOT_ACC)
            begin
                scan_reg     <= '0;
                distinct_reg <= '0;
            end
            else if (shift)
            begin
                scan_reg <= scan_reg + CW'(1);
                if (cvalid[N-1])
                begin
                    distinct_reg <= distinct_reg + CW'(1);
                end
            end

            // Hold the result until transfer
            if (state_reg == djent_pkg::ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept && sample_in.last_sample)
        begin
            tot_reg <= at_cap ? seen_reg : (seen_reg + CW'(1));
            ovf_reg <= drop_reg || at_cap;
        end

        if (state_reg == djent_pkg::ST_SCAN && lnq_start)
        begin
            cnt_reg <= ccount[N-1];
        end

        if (lnq_done)
        begin
            mul_reg <= ((state_reg == djent_pkg::ST_LN_TOT) ? tot_reg : cnt_reg) * lnq_q;
        end

        if (state_reg == djent_pkg::ST_TOT_ACC)
        begin
            t_reg <= mul_reg;
            s_reg <= '0;
        end
        else if (state_reg == djent_pkg::ST_ACC)
        begin
            s_reg <= s_reg + mul_reg;
        end

        if (state_reg == djent_pkg::ST_DONE && out_free)
        begin
            out_ent_reg  <= div_q;
            out_dist_reg <= 11'(distinct_reg);
            out_tot_reg  <= 11'(tot_reg);
            out_ovf_reg  <= ovf_reg;
        end
    end

    assign result_out.valid             = out_valid_reg;
    assign result_out.entropy_nats      = out_ent_reg;
    assign result_out.distinct_patterns = out_dist_reg;
    assign result_out.sample_total      = out_tot_reg;
    assign result_out.overflow          = out_ovf_reg;

endmodule

// ===== rtl/djent_chk.sv =====
// Port-level checks for the discrete joint entropy block, bound to the top level.
module djent_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_entropy,
    input logic [10:0] out_distinct
);

    // No result is offered while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // A stalled result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_entropy))
        else $error("result changed while stalled");

    // Closing a set stops intake while the entropy is worked out
    a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("sample taken right after the last one");

    // A single pattern carries no information
    a_one_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_distinct == 11'd1 |-> out_entropy == 32'd0)
        else $error("nonzero entropy for one pattern");

endmodule

bind discrete_joint_entropy djent_chk u_djent_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sample_in.valid),
    .in_ready     (sample_in.ready),
    .in_last      (sample_in.last_sample),
    .out_valid    (result_out.valid),
    .out_ready    (result_out.ready),
    .out_entropy  (result_out.entropy_nats),
    .out_distinct (result_out.distinct_patterns)
);

// ===== tb/sv/discrete_joint_entropy_test.sv =====
// Self-checking testbench for the discrete joint entropy block.
`timescale 1ns / 100ps

module discrete_joint_entropy_test;

    localparam int unsigned CAPACITY    = 1024;
    localparam int unsigned CYCLE_CAP   = 1_500_000;
    localparam int unsigned ITEM_COUNT  = 500;
    localparam int unsigned HOLD_CYCLES = 8000;

    typedef struct {
        logic [31:0] entropy;
        logic [10:0] distinct;
        logic [10:0] total;
        logic        dropped;
    } summary_t;

    typedef struct {
        int          num_vars;   // -1: keep the current setting
        logic [15:0] value [4];
        logic        last;
        bit          typed;
        summary_t    known;
    } sample_row_t;

    logic clk;
    logic rst_n;

    djent_sample_if sample_ch ();
    djent_result_if result_ch ();
    djent_cfg_if    cfg_ch ();

    discrete_joint_entropy dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_ch),
        .result_out (result_ch),
        .cfg        (cfg_ch)
    );

    // Shadow of the block's counting state
    logic [63:0] seen_keys   [CAPACITY];
    int unsigned seen_counts [CAPACITY];
    int unsigned key_count;
    int unsigned sample_count;
    bit          drop_seen;
    logic [2:0]  lanes_reg;

    summary_t    pending_summaries [$];
    sample_row_t stim_rows [$];
    int          error_count;
    int unsigned result_count;
    int unsigned cycle_count;
    bit          burst_mode;
    bit          hold_off = 1'b1;

    // ln(x) in Q.28 by repeated squaring of the normalized mantissa
    function automatic logic [63:0] log_nat_q28(int unsigned x);
        int unsigned e;
        logic [63:0] m;
        logic [63:0] frac;
        logic [63:0] l2;
        frac = 0;
        e = 0;
        if (x == 0)
            return 0;
        while ((x >> (e + 1)) != 0)
            e++;
        m = 64'(x) << (31 - e);
        for (int i = 0; i < djent_pkg::LN_FRAC_BITS; i++)
        begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000)
            begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        l2 = (64'(e) << djent_pkg::LN_FRAC_BITS) | frac;
        return (l2 * 64'(djent_pkg::LN2_Q32)) >> 32;
    endfunction

    function automatic logic [31:0] joint_entropy_q28();
        logic [63:0] s;
        logic [63:0] t;
        s = 0;
        if (sample_count == 0)
            return 0;
        for (int i = 0; i < key_count; i++)
            s += 64'(seen_counts[i]) * log_nat_q28(seen_counts[i]);
        t = 64'(sample_count) * log_nat_q28(sample_count);
        if (s >= t)
            return 0;
        return 32'((t - s) / sample_count);
    endfunction

    // Count one accepted sample; return the set summary when it closes the set
    function automatic bit tally_sample(sample_row_t r, output summary_t sum);
        int unsigned k;
        logic [63:0] key;
        bit          hit;
        k = (lanes_reg == 0) ? 1 : (lanes_reg > 4) ? 4 : lanes_reg;
        key = 0;
        hit = 0;
        for (int i = 0; i < k; i++)
            key |= 64'(r.value[i]) << (djent_pkg::FIELD_BITS * i);
        if (sample_count >= CAPACITY)
            drop_seen = 1;
        else
        begin
            for (int i = 0; i < key_count && !hit; i++)
                if (seen_keys[i] == key)
                begin
                    seen_counts[i]++;
                    hit = 1;
                end
            if (!hit)
            begin
                seen_keys[key_count] = key;
                seen_counts[key_count] = 1;
                key_count++;
            end
            sample_count++;
        end
        if (!r.last)
            return 0;
        sum.entropy  = joint_entropy_q28();
        sum.distinct = 11'(key_count);
        sum.total    = 11'(sample_count);
        sum.dropped  = drop_seen;
        key_count = 0;
        sample_count = 0;
        drop_seen = 0;
        return 1;
    endfunction

    function automatic void add_row(int nv, logic [15:0] a, logic [15:0] b,
                                    logic [15:0] c, logic [15:0] d, logic last,
                                    bit typed = 0, logic [31:0] ent = 0,
                                    logic [10:0] dis = 0, logic [10:0] tot = 0,
                                    logic ovf = 0);
        sample_row_t r;
        r.num_vars = nv;
        r.value[0] = a;
        r.value[1] = b;
        r.value[2] = c;
        r.value[3] = d;
        r.last = last;
        r.typed = typed;
        r.known.entropy = ent;
        r.known.distinct = dis;
        r.known.total = tot;
        r.known.dropped = ovf;
        stim_rows.push_back(r);
    endfunction

    // Clock
    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_CAP)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Long receiver hold-off after reset while the first sets keep coming
    initial
    begin
        @(posedge rst_n);
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // Hold off until every summary is back, then let the block settle
    task automatic wait_idle(int unsigned settle);
        while (pending_summaries.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_num_vars(logic [2:0] nv);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= nv;
        do @(negedge clk); while (!cfg_ch.ready);
        @(posedge clk);
        cfg_ch.valid <= 1'b0;
        lanes_reg = nv;
    endtask

    // Offer one sample after a random gap and predict on transfer
    task automatic send_sample(sample_row_t r);
        int unsigned gap;
        summary_t    sum;
        gap = burst_mode ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.value_0     <= r.value[0];
        sample_ch.value_1     <= r.value[1];
        sample_ch.value_2     <= r.value[2];
        sample_ch.value_3     <= r.value[3];
        sample_ch.last_sample <= r.last;
        do @(negedge clk); while (!sample_ch.ready);
        @(posedge clk);
        if (tally_sample(r, sum))
            pending_summaries.push_back(r.typed ? r.known : sum);
    endtask

    // Close a set: drop valid, wait for the result, optionally reprogram
    task automatic end_set(int nv);
        sample_ch.valid <= 1'b0;
        wait_idle(20);
        if (nv >= 0)
            write_num_vars(3'(nv));
    endtask

    // Result side: random stalls, plus the long hold-off after reset
    initial
    begin
        int unsigned stall;
        result_ch.ready = 1'b0;
        result_count = 0;
        error_count = 0;
        @(posedge rst_n);
        forever
        begin
            summary_t want;
            stall = burst_mode ? 0 : $urandom_range(0, 11);
            if (stall > 0 || hold_off)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                while (hold_off)
                    @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(negedge clk); while (!result_ch.valid);
            if (pending_summaries.size() == 0)
            begin
                $error("result transfer with no expectation pending");
                error_count++;
            end
            else
            begin
                want = pending_summaries.pop_front();
                if (result_ch.entropy_nats !== want.entropy)
                begin
                    $error("entropy_nats: expected %h, got %h", want.entropy,
                           result_ch.entropy_nats);
                    error_count++;
                end
                if (result_ch.distinct_patterns !== want.distinct)
                begin
                    $error("distinct_patterns: expected %0d, got %0d", want.distinct,
                           result_ch.distinct_patterns);
                    error_count++;
                end
                if (result_ch.sample_total !== want.total)
                begin
                    $error("sample_total: expected %0d, got %0d", want.total,
                           result_ch.sample_total);
                    error_count++;
                end
                if (result_ch.overflow !== want.dropped)
                begin
                    $error("overflow: expected %0d, got %0d", want.dropped,
                           result_ch.overflow);
                    error_count++;
                end
            end
            result_count++;
            @(posedge clk);
        end
    end

    // Stimulus
    initial
    begin
        int unsigned sent;
        int unsigned set_len;
        logic [15:0] pool [4][3];
        sample_row_t r;

        rst_n = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.value_0 = '0;
        sample_ch.value_1 = '0;
        sample_ch.value_2 = '0;
        sample_ch.value_3 = '0;
        sample_ch.last_sample = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        lanes_reg = 3'd1;
        key_count = 0;
        sample_count = 0;
        drop_seen = 0;
        burst_mode = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sets; num_vars applies from the row that opens a set
        add_row(-1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1,
                1, 32'h0, 11'd1, 11'd1, 0);
        add_row(-1, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0000, 0);
        add_row(-1, 16'h8000, 16'hFFFF, 16'h0000, 16'h0000, 1,
                1, 32'h0B17217F, 11'd2, 11'd2, 0);
        // unused lanes are masked off
        add_row(-1, 16'hFFFF, 16'h1234, 16'h8000, 16'h7FFF, 0);
        add_row(-1, 16'hFFFF, 16'hEDCB, 16'h7FFF, 16'h8000, 1,
                1, 32'h0, 11'd1, 11'd2, 0);
        add_row(4, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 0);
        add_row(-1, 16'h0001, 16'h0002, 16'h0003, 16'h0005, 0);
        add_row(-1, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 1);
        // num_vars of zero acts as one
        add_row(0, 16'h0005, 16'h0009, 16'h0000, 16'h0000, 0);
        add_row(-1, 16'h0005, 16'h0001, 16'hAAAA, 16'h5555, 1,
                1, 32'h0, 11'd1, 11'd2, 0);
        // num_vars above the lane count acts as four
        add_row(7, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 0);
        add_row(-1, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFE, 0);
        add_row(-1, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 0);
        add_row(-1, 16'h8000, 16'h7FFE, 16'h0000, 16'hFFFF, 1);
        add_row(2, 16'h5555, 16'hAAAA, 16'h0001, 16'h0000, 0);
        add_row(-1, 16'h5555, 16'hAAAB, 16'h0002, 16'h0000, 0);
        add_row(-1, 16'h5555, 16'hAAAA, 16'h0003, 16'h0000, 1);
        add_row(3, 16'h0000, 16'h0000, 16'h0001, 16'h1111, 0);
        add_row(-1, 16'h0000, 16'h0000, 16'h0002, 16'h2222, 0);
        add_row(-1, 16'h0000, 16'h0000, 16'h0001, 16'h3333, 0);
        add_row(-1, 16'h0000, 16'h0000, 16'h0001, 16'h4444, 1);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].num_vars >= 0)
                end_set(stim_rows[i].num_vars);
            send_sample(stim_rows[i]);
        end
        end_set(-1);

        // Random sets over small value pools so that patterns repeat
        sent = 0;
        while (sent < ITEM_COUNT)
        begin
            burst_mode = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) != 0)
                end_set($urandom_range(0, 7));
            foreach (pool[l, j])
                pool[l][j] = 16'($urandom());
            set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                                  : $urandom_range(1, 24);
            r.typed = 0;
            r.num_vars = -1;
            for (int n = 0; n < set_len; n++)
            begin
                for (int l = 0; l < 4; l++)
                    r.value[l] = ($urandom_range(0, 9) < 8)
                                 ? pool[l][$urandom_range(0, 2)] : 16'($urandom());
                r.last = (n == set_len - 1);
                send_sample(r);
                sent++;
            end
            end_set(-1);
        end

        // Fill to capacity with distinct patterns, then overrun it
        burst_mode = 1;
        end_set(1);
        r.typed = 0;
        for (int n = 0; n < CAPACITY + 6; n++)
        begin
            r.value[0] = (n < CAPACITY) ? 16'(n) : 16'($urandom());
            r.value[1] = 16'($urandom());
            r.value[2] = 16'($urandom());
            r.value[3] = 16'($urandom());
            r.last = (n == CAPACITY + 5);
            send_sample(r);
        end
        burst_mode = 0;
        sample_ch.valid <= 1'b0;
        wait_idle(200);

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== discrete_joint_entropy.f =====
rtl/djent_pkg.sv
rtl/djent_if.sv
rtl/djent_cell.sv
rtl/djent_lnq.sv
rtl/djent_div.sv
rtl/discrete_joint_entropy.sv
rtl/djent_chk.sv
tb/sv/discrete_joint_entropy_test.sv
